// ===== design/hmve_pkg.sv =====
// ----------------------------------------------------------------------------
// hmve_pkg
// Shared types and constants of the heightmap mesh vertex emitter.
// ----------------------------------------------------------------------------
package hmve_pkg;

   localparam int DIM_W       = 11;
   localparam int SCALE_W     = 24;
   localparam int COORD_W     = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int DIM_MIN     = 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_SCALE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_MODE   = 2'd3;

   localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 11'd2;
   localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 11'd2;
   localparam logic [SCALE_W-1:0] RST_UNIT_SCALE   = 24'd20480;

   // corner codes: bit 1 = next row, bit 0 = next column
   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_TR = 2'd1;
   localparam logic [1:0] CORNER_BL = 2'd2;
   localparam logic [1:0] CORNER_BR = 2'd3;

   localparam logic [2:0] TRI_LAST = 3'd5;
   localparam logic [2:0] PNT_LAST = 3'd3;

   localparam int GRAY_WR = 11;
   localparam int GRAY_WG = 16;
   localparam int GRAY_WB = 5;

   localparam int X_BIAS      = 16;
   localparam int X_SHIFT     = 5;
   localparam int Z_BIAS      = 8;
   localparam int Z_SHIFT     = 4;
   localparam int Y_BIAS      = 80;
   localparam int Y_PRE_SHIFT = 5;
   localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
   localparam int RECIP5_SHIFT = 34;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [SCALE_W-1:0] unit_scale;
      logic               point_mode;
   } cfg_type;

   function automatic logic [1:0] corner_sel(input logic point_mode, input logic [2:0] k);
      logic [1:0] sel;
      sel = CORNER_BL;
      if (point_mode) begin
         case (k)
            3'd0:    sel = CORNER_TL;
            3'd1:    sel = CORNER_BL;
            3'd2:    sel = CORNER_BR;
            default: sel = CORNER_BL;
         endcase
      end else begin
         case (k)
            3'd0:    sel = CORNER_TL;
            3'd1:    sel = CORNER_TR;
            3'd2:    sel = CORNER_BL;
            3'd3:    sel = CORNER_TR;
            3'd4:    sel = CORNER_BR;
            default: sel = CORNER_BL;
         endcase
      end
      return sel;
   endfunction

   function automatic logic [7:0] gray_of(input pixel_type p);
      logic [12:0] sum;
      sum = 13'(p.red) * 13'(GRAY_WR) + 13'(p.green) * 13'(GRAY_WG)
          + 13'(p.blue) * 13'(GRAY_WB);
      return sum[12:5];
   endfunction

endpackage

// ===== design/hmve_if.sv =====
// ----------------------------------------------------------------------------
// hmve interfaces
// Pixel, vertex and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hmve_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface hmve_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [7:0]         out_red;
   logic [7:0]         out_green;
   logic [7:0]         out_blue;
   logic               last_of_cell;
   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output out_red, output out_green, output out_blue,
                   output last_of_cell, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input out_red, input out_green, input out_blue,
                   input last_of_cell, output ready);
endinterface

interface hmve_csr_if;
   logic                             valid;
   logic                             ready;
   logic [hmve_pkg::CSR_IDX_W-1:0]   index;
   logic [hmve_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/hmve_queue.sv =====
// ----------------------------------------------------------------------------
// hmve_queue
// Small register FIFO of closed cells between front and back.
// ----------------------------------------------------------------------------
module hmve_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW   = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < CNTW'(DEPTH))
      else $error("queue write while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |=> $past(count_ff) != '0)
      else $error("queue read while empty");

endmodule

// ===== design/hmve_front.sv =====
// ----------------------------------------------------------------------------
// hmve_front
// Pixel intake: raster counters, line buffer, corner capture of closed cells.
// ----------------------------------------------------------------------------
module hmve_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   hmve_req_if.sink                          req,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]   eff_height,
   input  logic                              queue_full,
   output logic                              cell_push,
   output logic [$clog2(MAX_HEIGHT)-1:0]     cell_row,
   output logic [$clog2(MAX_WIDTH)-1:0]      cell_col,
   output hmve_pkg::pixel_type [3:0]         cell_corners
);
   import hmve_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   pixel_type       line_buf_ff [MAX_WIDTH];
   pixel_type       above_ff;
   pixel_type       prev_cur_ff;
   pixel_type       prev_above_ff;
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic            fb_valid_ff;
   logic            fb_close_ff;
   logic [RW-1:0]   fb_row_ff;
   logic [CW-1:0]   fb_col_ff;
   pixel_type       fb_pix_ff;
   pixel_type       fb_left_ff;
   pixel_type       pix;
   logic            req_fire;
   logic            fb_adv;
   logic            col_wrap;
   logic            row_wrap;

   assign pix       = '{red: req.red, green: req.green, blue: req.blue};
   assign fb_adv    = fb_valid_ff && (!fb_close_ff || !queue_full);
   assign req.ready = !fb_valid_ff || fb_adv;
   assign req_fire  = req.valid && req.ready;
   assign cell_push = fb_valid_ff && fb_close_ff && !queue_full;
   assign cell_row  = fb_row_ff;
   assign cell_col  = fb_col_ff;

   always_comb begin
      cell_corners            = '0;
      cell_corners[CORNER_TL] = prev_above_ff;
      cell_corners[CORNER_TR] = above_ff;
      cell_corners[CORNER_BL] = fb_left_ff;
      cell_corners[CORNER_BR] = fb_pix_ff;
   end

   always_comb begin
      col_wrap = ({1'b0, col_ff} + (CW+1)'(1)) >= (CW+1)'(eff_width);
      row_wrap = ({1'b0, row_ff} + (RW+1)'(1)) >= (RW+1)'(eff_height);
      col_in   = col_ff + CW'(1);
      row_in   = row_ff;
      if (col_wrap) begin
         col_in = '0;
         row_in = row_wrap ? '0 : row_ff + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         fb_valid_ff   <= 1'b0;
         prev_cur_ff   <= '0;
         prev_above_ff <= '0;
      end else begin
         if (req_fire) begin
            col_ff      <= col_in;
            row_ff      <= row_in;
            prev_cur_ff <= pix;
            fb_valid_ff <= 1'b1;
         end else if (fb_adv) begin
            fb_valid_ff <= 1'b0;
         end
         if (fb_adv) begin
            prev_above_ff <= above_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         above_ff            <= line_buf_ff[col_ff];
         line_buf_ff[col_ff] <= pix;
         fb_close_ff         <= (row_ff != '0) && (col_ff != '0);
         fb_row_ff           <= row_ff - RW'(1);
         fb_col_ff           <= col_ff - CW'(1);
         fb_pix_ff           <= pix;
         fb_left_ff          <= prev_cur_ff;
      end
   end

   a_intake_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> fb_valid_ff)
      else $error("accepted word did not reach the capture stage");

endmodule

// ===== design/hmve_back.sv =====
// ----------------------------------------------------------------------------
// hmve_back
// Vertex sequencer and position pipeline with registered output word.
// ----------------------------------------------------------------------------
module hmve_back #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hmve_pkg::cfg_type                 cfg,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]   eff_height,
   input  logic                              cell_valid,
   input  logic [$clog2(MAX_HEIGHT)-1:0]     cell_row,
   input  logic [$clog2(MAX_WIDTH)-1:0]      cell_col,
   input  hmve_pkg::pixel_type [3:0]         cell_corners,
   output logic                              cell_pop,
   hmve_rsp_if.source                        rsp
);
   import hmve_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int HW   = $clog2(MAX_HEIGHT+1);
   localparam int XMW  = HW + 2;
   localparam int PXW  = SCALE_W + 1 + XMW;
   localparam int ZPW  = SCALE_W + CW;
   localparam int SATW = (PXW + 1 > 34) ? PXW + 1 : 34;
   localparam int ZSW  = (ZPW + 1 > 34) ? ZPW + 1 : 34;
   localparam int YNW  = 33 - Y_PRE_SHIFT;
   localparam int YPW  = YNW + 32;

   localparam logic signed [SATW-1:0] X_MAX = SATW'(32'sh7FFF_FFFF);
   localparam logic signed [SATW-1:0] X_MIN = SATW'(32'sh8000_0000);
   localparam logic        [ZSW-1:0]  Z_MAX = ZSW'(32'h7FFF_FFFF);

   logic [2:0]               k_ff, k_in;
   logic                     en;
   logic                     is_last;
   logic [1:0]               sel;

   logic                     v0_valid_ff;
   logic [RW-1:0]            v0_row_ff;
   logic [CW-1:0]            v0_col_ff;
   pixel_type                v0_pix_ff;
   logic                     v0_last_ff;

   logic                     v1_valid_ff;
   logic signed [PXW-1:0]    v1_px_ff;
   logic [ZPW-1:0]           v1_pz_ff;
   logic [31:0]              v1_py_ff;
   pixel_type                v1_pix_ff;
   logic                     v1_last_ff;

   logic                     v2_valid_ff;
   logic [31:0]              v2_x_ff;
   logic [31:0]              v2_z_ff;
   logic [YPW-1:0]           v2_yp_ff;
   pixel_type                v2_pix_ff;
   logic                     v2_last_ff;

   logic                     out_valid_ff;
   logic [31:0]              out_x_ff;
   logic [31:0]              out_y_ff;
   logic [31:0]              out_z_ff;
   pixel_type                out_pix_ff;
   logic                     out_last_ff;

   logic [7:0]               gray;
   logic signed [XMW-1:0]    xm;
   logic signed [PXW-1:0]    px;
   logic [ZPW-1:0]           pz;
   logic [31:0]              py;
   logic signed [SATW-1:0]   xsum;
   logic signed [SATW-1:0]   xsh;
   logic [31:0]              xsat;
   logic [ZSW-1:0]           zsh;
   logic [31:0]              zsat;
   logic [32:0]              ysum;
   logic [YPW-1:0]           yp;

   assign en       = !out_valid_ff || rsp.ready;
   assign is_last  = cfg.point_mode ? (k_ff >= PNT_LAST) : (k_ff >= TRI_LAST);
   assign sel      = corner_sel(cfg.point_mode, k_ff);
   assign cell_pop = en && cell_valid && is_last;

   always_comb begin
      k_in = k_ff;
      if (en && cell_valid) begin
         k_in = is_last ? 3'd0 : k_ff + 3'd1;
      end
   end

   always_comb begin
      gray = gray_of(v0_pix_ff);
      xm   = $signed(XMW'({v0_row_ff, 1'b0})) - $signed(XMW'(eff_height));
      px   = $signed({1'b0, cfg.unit_scale}) * xm;
      pz   = ZPW'(cfg.unit_scale) * ZPW'(v0_col_ff);
      py   = 32'(cfg.unit_scale) * 32'(gray);
   end

   always_comb begin
      xsum = SATW'(v1_px_ff) + SATW'(X_BIAS);
      xsh  = xsum >>> X_SHIFT;
      if (xsh > X_MAX) begin
         xsat = X_MAX[31:0];
      end else if (xsh < X_MIN) begin
         xsat = X_MIN[31:0];
      end else begin
         xsat = xsh[31:0];
      end
      zsh  = (ZSW'(v1_pz_ff) + ZSW'(Z_BIAS)) >> Z_SHIFT;
      zsat = (zsh > Z_MAX) ? Z_MAX[31:0] : zsh[31:0];
      ysum = {1'b0, v1_py_ff} + 33'(Y_BIAS);
      yp   = YPW'(ysum[32:Y_PRE_SHIFT]) * YPW'(RECIP5);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= 3'd0;
         v0_valid_ff  <= 1'b0;
         v1_valid_ff  <= 1'b0;
         v2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         k_ff <= k_in;
         if (en) begin
            v0_valid_ff  <= cell_valid;
            v1_valid_ff  <= v0_valid_ff;
            v2_valid_ff  <= v1_valid_ff;
            out_valid_ff <= v2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v0_row_ff   <= cell_row + RW'(sel[1]);
         v0_col_ff   <= cell_col + CW'(sel[0]);
         v0_pix_ff   <= cell_corners[sel];
         v0_last_ff  <= is_last;

         v1_px_ff    <= px;
         v1_pz_ff    <= pz;
         v1_py_ff    <= py;
         v1_pix_ff   <= v0_pix_ff;
         v1_last_ff  <= v0_last_ff;

         v2_x_ff     <= xsat;
         v2_z_ff     <= zsat;
         v2_yp_ff    <= yp;
         v2_pix_ff   <= v1_pix_ff;
         v2_last_ff  <= v1_last_ff;

         out_x_ff    <= v2_x_ff;
         out_y_ff    <= 32'(v2_yp_ff[YPW-1:RECIP5_SHIFT]);
         out_z_ff    <= v2_z_ff;
         out_pix_ff  <= v2_pix_ff;
         out_last_ff <= v2_last_ff;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.pos_x        = $signed(out_x_ff);
   assign rsp.pos_y        = $signed(out_y_ff);
   assign rsp.pos_z        = $signed(out_z_ff);
   assign rsp.out_red      = out_pix_ff.red;
   assign rsp.out_green    = out_pix_ff.green;
   assign rsp.out_blue     = out_pix_ff.blue;
   assign rsp.last_of_cell = out_last_ff;

   a_seq_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= TRI_LAST)
      else $error("vertex sequencer out of range");

   a_pop_restarts: assert property (@(posedge clock) disable iff (reset)
      cell_pop |=> k_ff == 3'd0)
      else $error("sequencer did not restart after cell");

endmodule

// ===== design/heightmap_mesh_vertex_emitter.sv =====
// ----------------------------------------------------------------------------
// heightmap_mesh_vertex_emitter
// Turns a raster stream of RGB heightmap pixels into mesh vertices.
//
//   port      dir   word                          handshake
//   req_bus   in    red, green, blue              valid/ready
//   rsp_bus   out   pos_x/y/z, rgb, last_of_cell  valid/ready
//   csr_bus   in    index, data                   valid/ready (always ready)
//
// Each closing pixel yields 6 vertices (4 in point mode), one per cycle from
// the back sequencer while rsp_bus is ready; row 0 and column 0 pixels are
// taken every cycle while the queue has room. The pixel's cell passes the
// capture register, the queue and the v0, v1, v2 and out stages before its
// first vertex word is valid. Synchronous reset clears counters, queue and
// pipeline; the line buffer is not cleared. A stalled rsp_bus freezes the back
// pipeline only; the 4-cell queue lets the front keep taking pixels until full.
// ----------------------------------------------------------------------------
module heightmap_mesh_vertex_emitter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   hmve_req_if.sink    req_bus,
   hmve_rsp_if.source  rsp_bus,
   hmve_csr_if.sink    csr_bus
);
   import hmve_pkg::*;

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int RW     = $clog2(MAX_HEIGHT);
   localparam int WW     = $clog2(MAX_WIDTH+1);
   localparam int HW     = $clog2(MAX_HEIGHT+1);
   localparam int EXT_W  = (WW > DIM_W) ? ((WW > HW) ? WW : HW)
                                        : ((DIM_W > HW) ? DIM_W : HW);
   localparam int CELL_W = RW + CW + 4 * $bits(pixel_type);

   logic [DIM_W-1:0]     width_ff;
   logic [DIM_W-1:0]     height_ff;
   logic [SCALE_W-1:0]   scale_ff;
   logic                 point_ff;
   logic [EXT_W-1:0]     width_ext;
   logic [EXT_W-1:0]     height_ext;
   logic [WW-1:0]        eff_width;
   logic [HW-1:0]        eff_height;
   cfg_type              cfg;

   logic                 f_push;
   logic [RW-1:0]        f_row;
   logic [CW-1:0]        f_col;
   pixel_type [3:0]      f_corners;
   logic                 q_full;
   logic                 q_empty;
   logic                 q_pop;
   logic [CELL_W-1:0]    q_data;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         scale_ff  <= RST_UNIT_SCALE;
         point_ff  <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_bus.data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_bus.data[DIM_W-1:0];
            CSR_UNIT_SCALE:   scale_ff  <= csr_bus.data[SCALE_W-1:0];
            CSR_POINT_MODE:   point_ff  <= csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_ext  = EXT_W'(width_ff);
      height_ext = EXT_W'(height_ff);
      if (width_ext < EXT_W'(DIM_MIN)) begin
         width_ext = EXT_W'(DIM_MIN);
      end else if (width_ext > EXT_W'(MAX_WIDTH)) begin
         width_ext = EXT_W'(MAX_WIDTH);
      end
      if (height_ext < EXT_W'(DIM_MIN)) begin
         height_ext = EXT_W'(DIM_MIN);
      end else if (height_ext > EXT_W'(MAX_HEIGHT)) begin
         height_ext = EXT_W'(MAX_HEIGHT);
      end
      eff_width      = width_ext[WW-1:0];
      eff_height     = height_ext[HW-1:0];
      cfg.unit_scale = scale_ff;
      cfg.point_mode = point_ff;
   end

   hmve_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .eff_width    (eff_width),
      .eff_height   (eff_height),
      .queue_full   (q_full),
      .cell_push    (f_push),
      .cell_row     (f_row),
      .cell_col     (f_col),
      .cell_corners (f_corners)
   );

   hmve_queue #(
      .WIDTH (CELL_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_row, f_col, f_corners}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   hmve_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .eff_height   (eff_height),
      .cell_valid   (!q_empty),
      .cell_row     (q_data[CELL_W-1 -: RW]),
      .cell_col     (q_data[CELL_W-RW-1 -: CW]),
      .cell_corners (q_data[4*$bits(pixel_type)-1:0]),
      .cell_pop     (q_pop),
      .rsp          (rsp_bus)
   );

endmodule

// ===== verif/heightmap_mesh_vertex_emitter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heightmap_mesh_vertex_emitter_tb
// Streams raster pixels into the emitter and checks every vertex word.
// A tracker class mirrors the line buffer, counters and registers, builds the
// expected vertices of each closed cell and compares them in order with the
// rsp_bus words. Covers both modes, dimension saturation, mid-image register
// writes, the widest width setting, a tall image and a long output stall.
// ----------------------------------------------------------------------------
module heightmap_mesh_vertex_emitter_tb;
   import hmve_pkg::*;

   localparam int    MAX_DIM     = 1024;
   localparam int    HOLD_CYCLES = 300;
   localparam int    QUIET_LIMIT = 4000;
   localparam int    PIXEL_TARGET = 370;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   typedef struct {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      pixel_type                 color;
      logic                      last_of_cell;
   } vertex_type;

   class mesh_tracker_type;
      logic [DIM_W-1:0]   width_reg;
      logic [DIM_W-1:0]   height_reg;
      logic [SCALE_W-1:0] scale_reg;
      logic               point_reg;
      pixel_type          line_buf [MAX_DIM];
      pixel_type          left_px;
      pixel_type          upper_left_px;
      int unsigned        row_idx;
      int unsigned        col_idx;
      int unsigned        filled_cols;
      vertex_type         pending [$];
      int unsigned        mismatches;
      int unsigned        pixels_seen;
      int unsigned        vertices_seen;
      int unsigned        writes_seen;

      function new();
         width_reg     = RST_IMAGE_WIDTH;
         height_reg    = RST_IMAGE_HEIGHT;
         scale_reg     = RST_UNIT_SCALE;
         point_reg     = 1'b0;
         left_px       = '0;
         upper_left_px = '0;
         row_idx       = 0;
         col_idx       = 0;
         filled_cols   = 0;
         mismatches    = 0;
         pixels_seen   = 0;
         vertices_seen = 0;
         writes_seen   = 0;
         foreach (line_buf[k]) line_buf[k] = '0;
      endfunction

      function int unsigned dim_limit(int unsigned v);
         if (v < DIM_MIN) return DIM_MIN;
         if (v > MAX_DIM) return MAX_DIM;
         return v;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         writes_seen++;
         case (idx)
            CSR_IMAGE_WIDTH:  width_reg  = value[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_reg = value[DIM_W-1:0];
            CSR_UNIT_SCALE:   scale_reg  = value[SCALE_W-1:0];
            CSR_POINT_MODE:   point_reg  = value[0];
            default: ;
         endcase
      endfunction

      // widening mid-image must not expose line buffer entries never written
      function bit may_widen(logic [DIM_W-1:0] raw);
         return row_idx == 0 || dim_limit(raw) <= filled_cols;
      endfunction

      function bit at_boundary();
         return row_idx == 0 && col_idx == 0;
      endfunction

      function logic signed [31:0] sat32(longint v);
         if (v > S32_MAX) return S32_MAX[31:0];
         if (v < S32_MIN) return S32_MIN[31:0];
         return v[31:0];
      endfunction

      function vertex_type make_vertex(int unsigned row, int unsigned col, pixel_type px,
                                       bit closing, int unsigned h);
         vertex_type  v;
         longint      s;
         longint      gray;
         s            = longint'(scale_reg);
         gray         = (11 * px.red + 16 * px.green + 5 * px.blue) / 32;
         // x in 2^-21 units, z in 2^-20, both rounded half up to 2^-16
         v.pos_x      = sat32((s * (2 * longint'(row) - longint'(h)) + 16) >>> 5);
         v.pos_y      = sat32((s * gray + 80) / 160);
         v.pos_z      = sat32((s * longint'(col) + 8) >>> 4);
         v.color      = px;
         v.last_of_cell = closing;
         return v;
      endfunction

      function void note_pixel(pixel_type px);
         int unsigned w;
         int unsigned h;
         int unsigned i;
         int unsigned j;
         pixel_type   above;
         w     = dim_limit(width_reg);
         h     = dim_limit(height_reg);
         above = line_buf[col_idx];
         pixels_seen++;
         if (row_idx >= 1 && col_idx >= 1) begin
            i = row_idx - 1;
            j = col_idx - 1;
            pending.push_back(make_vertex(i, j, upper_left_px, 1'b0, h));
            if (point_reg) begin
               pending.push_back(make_vertex(i + 1, j, left_px, 1'b0, h));
               pending.push_back(make_vertex(i + 1, j + 1, px, 1'b0, h));
            end else begin
               pending.push_back(make_vertex(i, j + 1, above, 1'b0, h));
               pending.push_back(make_vertex(i + 1, j, left_px, 1'b0, h));
               pending.push_back(make_vertex(i, j + 1, above, 1'b0, h));
               pending.push_back(make_vertex(i + 1, j + 1, px, 1'b0, h));
            end
            pending.push_back(make_vertex(i + 1, j, left_px, 1'b1, h));
         end
         upper_left_px     = above;
         line_buf[col_idx] = px;
         left_px           = px;
         if (col_idx + 1 > filled_cols) filled_cols = col_idx + 1;
         if (col_idx + 1 >= w) begin
            col_idx = 0;
            row_idx = (row_idx + 1 >= h) ? 0 : row_idx + 1;
         end else begin
            col_idx = col_idx + 1;
         end
      endfunction

      function void compare_field(string field, logic [31:0] want_v, logic [31:0] got_v);
         if (got_v !== want_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h",
                     $time, field, want_v, got_v);
         end
      endfunction

      function void check_vertex(vertex_type got);
         vertex_type want;
         vertices_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected vertex x=0x%08h y=0x%08h z=0x%08h rgb=%06h last=%b",
                     $time, got.pos_x, got.pos_y, got.pos_z, got.color, got.last_of_cell);
            return;
         end
         want = pending.pop_front();
         compare_field("pos_x", want.pos_x, got.pos_x);
         compare_field("pos_y", want.pos_y, got.pos_y);
         compare_field("pos_z", want.pos_z, got.pos_z);
         compare_field("out_red", {24'd0, want.color.red}, {24'd0, got.color.red});
         compare_field("out_green", {24'd0, want.color.green}, {24'd0, got.color.green});
         compare_field("out_blue", {24'd0, want.color.blue}, {24'd0, got.color.blue});
         compare_field("last_of_cell", {31'd0, want.last_of_cell},
                       {31'd0, got.last_of_cell});
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;
   bit   stall_request;
   int   hold_left;
   int   quiet_cycles;

   mesh_tracker_type tracker;

   hmve_req_if req_bus ();
   hmve_rsp_if rsp_bus ();
   hmve_csr_if csr_bus ();

   heightmap_mesh_vertex_emitter i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic pixel_type rand_pixel();
      pixel_type p;
      p.red   = rand_byte();
      p.green = rand_byte();
      p.blue  = rand_byte();
      return p;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_dim(int unsigned top);
      if ($urandom_range(5) == 0) return CSR_DATA_W'($urandom_range(1));
      return CSR_DATA_W'($urandom_range(top, 2));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_scale();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         default: return CSR_DATA_W'($urandom_range(24'hFFFFFF));
      endcase
   endfunction

   task automatic send_pixel(pixel_type px);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 12) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.red   = px.red;
      req_bus.green = px.green;
      req_bus.blue  = px.blue;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_pixel(px);
   endtask

   task automatic program_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.write_reg(idx, value);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // stop offering, drain all vertices, then cover the input-to-output latency
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic finish_image();
      while (!tracker.at_boundary()) send_pixel(rand_pixel());
   endtask

   // vertex sink: random backpressure plus one long hold-off on request
   initial begin
      vertex_type got;
      rsp_bus.ready = 1'b0;
      hold_left     = 0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            hold_left     = HOLD_CYCLES;
            stall_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = steady || $urandom_range(99) >= 12;
         end
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.pos_x        = rsp_bus.pos_x;
            got.pos_y        = rsp_bus.pos_y;
            got.pos_z        = rsp_bus.pos_z;
            got.color.red    = rsp_bus.out_red;
            got.color.green  = rsp_bus.out_green;
            got.color.blue   = rsp_bus.out_blue;
            got.last_of_cell = rsp_bus.last_of_cell;
            tracker.check_vertex(got);
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: watchdog, no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int unsigned phase;
      int unsigned count;
      logic [CSR_DATA_W-1:0] raw;
      tracker       = new();
      steady        = 1'b0;
      stall_request = 1'b0;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.red   = '0;
      req_bus.green = '0;
      req_bus.blue  = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_IMAGE_WIDTH;
      csr_bus.data  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset config 2x2 triangles: row/col zero pixels give nothing, image wraps
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hFF0000);
      send_pixel(24'h00FF00);
      send_pixel(24'h0000FF);
      send_pixel(24'h808080);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h010101);
      settle_block();
      program_reg(CSR_POINT_MODE, 24'd1);
      program_reg(CSR_IMAGE_WIDTH, 24'd3);
      send_pixel(24'h123456);
      send_pixel(24'hFEDCBA);
      send_pixel(24'h00FF00);
      send_pixel(24'hFF00FF);
      send_pixel(24'h0F0F0F);
      send_pixel(24'hF0F0F0);
      settle_block();
      program_reg(CSR_IMAGE_HEIGHT, 24'd3);
      program_reg(CSR_POINT_MODE, 24'd0);
      repeat (5) send_pixel(rand_pixel());
      // narrow mid-row: column counter already past the new last column
      settle_block();
      program_reg(CSR_IMAGE_WIDTH, 24'd2);
      repeat (3) send_pixel(rand_pixel());

      // width saturated high, height saturated low, largest scale,
      // then narrowed inside the first row
      finish_image();
      settle_block();
      program_reg(CSR_IMAGE_WIDTH, 24'h0007FF);
      program_reg(CSR_IMAGE_HEIGHT, 24'd0);
      program_reg(CSR_UNIT_SCALE, 24'hFFFFFF);
      program_reg(CSR_POINT_MODE, 24'd1);
      repeat (40) send_pixel(rand_pixel());
      settle_block();
      program_reg(CSR_IMAGE_WIDTH, 24'd24);
      finish_image();

      // tall image with no idling, then cut short by a mid-image height write
      settle_block();
      program_reg(CSR_IMAGE_WIDTH, 24'd1);
      program_reg(CSR_IMAGE_HEIGHT, 24'h0007FF);
      program_reg(CSR_POINT_MODE, 24'd0);
      steady = 1'b1;
      repeat (64) send_pixel(rand_pixel());
      settle_block();
      steady = 1'b0;
      program_reg(CSR_IMAGE_HEIGHT, 24'd2);

      phase = 0;
      while (tracker.pixels_seen < PIXEL_TARGET) begin
         settle_block();
         if ($urandom_range(1)) begin
            raw = pick_dim(8);
            if (tracker.may_widen(raw[DIM_W-1:0])) program_reg(CSR_IMAGE_WIDTH, raw);
         end
         if ($urandom_range(1)) program_reg(CSR_IMAGE_HEIGHT, pick_dim(6));
         if ($urandom_range(2) == 0) program_reg(CSR_UNIT_SCALE, pick_scale());
         if ($urandom_range(1)) program_reg(CSR_POINT_MODE, CSR_DATA_W'($urandom_range(1)));
         if (phase == 1) stall_request = 1'b1;
         count = (phase == 1) ? 40 : $urandom_range(20, 6);
         repeat (count) send_pixel(rand_pixel());
         if ($urandom_range(3) != 0) finish_image();
         phase++;
      end
      settle_block();
      repeat (16) @(posedge clock);

      $display("run covered %0d pixels, %0d vertex words, %0d register writes",
               tracker.pixels_seen, tracker.vertices_seen, tracker.writes_seen);
      $display("both vertex modes, widths and heights 2..%0d, scale 0..max, output stall",
               MAX_DIM);
      if (tracker.mismatches == 0 && tracker.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
design/hmve_pkg.sv
design/hmve_if.sv
design/hmve_queue.sv
design/hmve_front.sv
design/hmve_back.sv
design/heightmap_mesh_vertex_emitter.sv
verif/heightmap_mesh_vertex_emitter_tb.sv
